[rtl/dlr_pkg.sv]
// Shared types, constants and helpers for the dense layer with ReLU.
`default_nettype none
package dlr_pkg;

	localparam int NUM_NEURONS = 4;
	localparam int NUM_INPUTS  = 4;
	localparam int VALUE_W     = 16;
	localparam int PROD_W      = 2 * VALUE_W;
	localparam int ACC_W       = 40;
	localparam int FRAC_BITS   = 12;
	localparam int CNT_W       = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 3;

	localparam logic [1:0] OP_WEIGHT  = 2'd0;
	localparam logic [1:0] OP_BIAS    = 2'd1;
	localparam logic [1:0] OP_FEATURE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NEURONS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INPUTS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELU    = 2'd2;

	typedef struct packed {
		logic [1:0]                opcode;
		logic [1:0]                neuron;
		logic [1:0]                column;
		logic signed [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [1:0]                neuron_index;
		logic signed [VALUE_W-1:0] neuron_value;
		logic                      saturated;
		logic                      last;
	} result_t;

	typedef logic [NUM_NEURONS-1:0][PROD_W-1:0]  prod_arr_t;
	typedef logic [NUM_NEURONS-1:0][VALUE_W-1:0] bias_arr_t;
	typedef logic [NUM_NEURONS-1:0][ACC_W-1:0]   acc_arr_t;

	typedef struct packed {
		logic valid;
		logic rowend;
	} s2_ctl_t;

	typedef struct packed {
		acc_arr_t         acc;
		bias_arr_t        bias;
		logic [CNT_W-1:0] nn;
		logic             relu;
	} row_t;

	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v,
		input logic [CNT_W-1:0] maxv);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/dlr_front.sv]
// Input register, weight and bias stores, and per-neuron multipliers.
`default_nettype none
module dlr_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              adv,
	input  wire logic                              item_valid,
	input  wire dlr_pkg::item_t                    item,
	input  wire logic [dlr_pkg::CNT_W-1:0]         nn,
	input  wire logic [dlr_pkg::CNT_W-1:0]         ni,
	output dlr_pkg::s2_ctl_t                       ctl_s2,
	output dlr_pkg::prod_arr_t                     prod_s2,
	output dlr_pkg::bias_arr_t                     bias_q
);
	import dlr_pkg::*;

	logic                valid_s1;
	item_t               item_s1;
	logic [VALUE_W-1:0]  weight_q [NUM_NEURONS][NUM_INPUTS];
	logic                feat;
	logic                rowend;
	prod_arr_t           prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv && item_s1.opcode == OP_WEIGHT
			&& {1'b0, item_s1.neuron} < CNT_W'(NUM_NEURONS)
			&& {1'b0, item_s1.column} < CNT_W'(NUM_INPUTS)) begin
			weight_q[item_s1.neuron][item_s1.column] <= item_s1.value;
		end
		if (valid_s1 && adv && item_s1.opcode == OP_BIAS
			&& {1'b0, item_s1.neuron} < CNT_W'(NUM_NEURONS)) begin
			bias_q[item_s1.neuron] <= item_s1.value;
		end
	end

	assign feat   = valid_s1 && item_s1.opcode == OP_FEATURE && {1'b0, item_s1.column} < ni;
	assign rowend = feat && {1'b0, item_s1.column} == ni - CNT_W'(1);

	always_comb begin
		for (int n = 0; n < NUM_NEURONS; n++) begin
			if (CNT_W'(n) < nn) begin
				prod[n] = PROD_W'($signed(item_s1.value)
					* $signed(weight_q[n][item_s1.column]));
			end else begin
				prod[n] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2.valid  <= feat;
			ctl_s2.rowend <= rowend;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= prod;
		end
	end

endmodule
`default_nettype wire

[rtl/dlr_accum.sv]
// Neuron accumulators and capture of a finished row.
`default_nettype none
module dlr_accum (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      adv,
	input  wire dlr_pkg::s2_ctl_t          ctl_s2,
	input  wire dlr_pkg::prod_arr_t        prod_s2,
	input  wire dlr_pkg::bias_arr_t        bias,
	input  wire logic [dlr_pkg::CNT_W-1:0] nn,
	input  wire logic                      relu,
	output logic                           row_load,
	output dlr_pkg::row_t                  row_next
);
	import dlr_pkg::*;

	acc_arr_t acc_q;
	acc_arr_t acc_sum;

	always_comb begin
		for (int n = 0; n < NUM_NEURONS; n++) begin
			acc_sum[n] = acc_q[n] + {{(ACC_W-PROD_W){prod_s2[n][PROD_W-1]}}, prod_s2[n]};
		end
	end

	assign row_load      = adv && ctl_s2.valid && ctl_s2.rowend;
	assign row_next.acc  = acc_sum;
	assign row_next.bias = bias;
	assign row_next.nn   = nn;
	assign row_next.relu = relu;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (adv && ctl_s2.valid) begin
			if (ctl_s2.rowend) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_sum;
			end
		end
	end

	a_clear_after_row: assert property (@(posedge clk) disable iff (!arst_n)
		row_load |=> acc_q == '0)
		else $error("accumulators not cleared after row end");

endmodule
`default_nettype wire

[rtl/dlr_out.sv]
// Row buffer, bias add, shift, saturation, ReLU and output register.
`default_nettype none
module dlr_out (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             row_load,
	input  wire dlr_pkg::row_t    row_in,
	output logic                  row_free,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output dlr_pkg::result_t      result
);
	import dlr_pkg::*;

	localparam int SUM_W = ACC_W + 1;
	localparam int SH_W  = SUM_W - FRAC_BITS;

	row_t                      row_q;
	logic                      row_valid_q;
	logic [1:0]                idx_q;
	logic                      out_valid_q;
	result_t                   out_q;
	logic                      out_load;
	logic                      last;
	logic [ACC_W-1:0]          acc;
	logic [VALUE_W-1:0]        b;
	logic [SUM_W-1:0]          sum;
	logic [SH_W-1:0]           sh;
	logic                      sat_hi;
	logic                      sat_lo;
	logic [VALUE_W-1:0]        val;
	result_t                   res;

	assign out_load = row_valid_q && (!out_valid_q || result_ready);
	assign last     = {1'b0, idx_q} == row_q.nn - CNT_W'(1);
	assign row_free = !row_valid_q || (out_load && last);

	always_comb begin
		acc    = row_q.acc[idx_q];
		b      = row_q.bias[idx_q];
		sum    = {acc[ACC_W-1], acc}
			+ {{(SUM_W-VALUE_W-FRAC_BITS){b[VALUE_W-1]}}, b, {FRAC_BITS{1'b0}}};
		sh     = sum[SUM_W-1:FRAC_BITS];
		sat_hi = !sh[SH_W-1] && (|sh[SH_W-2:VALUE_W-1]);
		sat_lo = sh[SH_W-1] && !(&sh[SH_W-2:VALUE_W-1]);
		if (sat_hi) begin
			val = {1'b0, {(VALUE_W-1){1'b1}}};
		end else if (sat_lo) begin
			val = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			val = sh[VALUE_W-1:0];
		end
		if (row_q.relu && val[VALUE_W-1]) begin
			val = '0;
		end
		res.neuron_index = idx_q;
		res.neuron_value = val;
		res.saturated    = sat_hi || sat_lo;
		res.last         = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (row_load) begin
			row_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (out_load && last) begin
			row_valid_q <= 1'b0;
		end else if (out_load) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (row_load) begin
			row_q <= row_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		row_load |-> row_free)
		else $error("row buffer overwritten while draining");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid_q |-> ({1'b0, idx_q} < row_q.nn))
		else $error("neuron index past active count");

	a_last_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && last && !row_load |=> !row_valid_q)
		else $error("row buffer still busy after last word");

endmodule
`default_nettype wire

[rtl/dense_layer_relu.sv]
// Top level of the fully connected layer with optional ReLU.
// Fully connected layer, signed Q3.12. Items (weight load, bias load or feature) are
// taken one per clock. A feature for the last active column closes the row; its
// results, one word per active neuron in neuron order, pass the input, product and
// row buffer registers into a single output register, one per clock when not stalled.
// The input stalls only while a closed row waits behind a row that is still draining,
// so a row of ni features yields nn results and ni >= nn streams without stall.
// Configuration writes must be made only while the block is idle; it does not check.
`default_nettype none
module dense_layer_relu (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [dlr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dlr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire dlr_pkg::item_t                  item,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output dlr_pkg::result_t                     result
);
	import dlr_pkg::*;

	logic [CNT_W-1:0] neurons_q;
	logic [CNT_W-1:0] inputs_q;
	logic             relu_q;
	logic [CNT_W-1:0] nn;
	logic [CNT_W-1:0] ni;
	logic             adv;
	logic             row_free;
	logic             row_load;
	s2_ctl_t          ctl_s2;
	prod_arr_t        prod_s2;
	bias_arr_t        bias;
	row_t             row_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neurons_q <= CNT_W'(4);
			inputs_q  <= CNT_W'(4);
			relu_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NEURONS: neurons_q <= cfg_data[CNT_W-1:0];
				REG_INPUTS:  inputs_q  <= cfg_data[CNT_W-1:0];
				REG_RELU:    relu_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign nn = eff_count(neurons_q, CNT_W'(NUM_NEURONS));
	assign ni = eff_count(inputs_q, CNT_W'(NUM_INPUTS));

	assign adv        = !(ctl_s2.valid && ctl_s2.rowend && !row_free);
	assign item_ready = adv;

	dlr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.item_valid (item_valid),
		.item       (item),
		.nn         (nn),
		.ni         (ni),
		.ctl_s2     (ctl_s2),
		.prod_s2    (prod_s2),
		.bias_q     (bias)
	);

	dlr_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_s2   (ctl_s2),
		.prod_s2  (prod_s2),
		.bias     (bias),
		.nn       (nn),
		.relu     (relu_q),
		.row_load (row_load),
		.row_next (row_next)
	);

	dlr_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.row_load     (row_load),
		.row_in       (row_next),
		.row_free     (row_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for dense_layer_relu: directed table, random rows, checked by a predictor.
module tb;
	import dlr_pkg::*;

	localparam logic [1:0]           OP_NONE     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
	localparam int                   HOLD_CYCLES = 300;
	localparam int                   PHASE_WORDS = 40;

	localparam logic [5:0][2:0] PLAN_NN   = {3'd3, 3'd7, 3'd2, 3'd4, 3'd1, 3'd4};
	localparam logic [5:0][2:0] PLAN_NI   = {3'd2, 3'd0, 3'd3, 3'd1, 3'd4, 3'd4};
	localparam logic [5:0]      PLAN_RELU = 6'b010101;

	typedef struct {
		bit               setup;
		logic [CNT_W-1:0] nn;
		logic [CNT_W-1:0] ni;
		logic             relu;
		item_t            w;
		bit               typed;
		result_t          want;
	} step_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;

	logic signed [VALUE_W-1:0] weights [NUM_NEURONS][NUM_INPUTS];
	logic signed [VALUE_W-1:0] biases [NUM_NEURONS];
	logic signed [ACC_W-1:0]   sums [NUM_NEURONS];
	logic [CNT_W-1:0]          neurons_cfg = 3'd4;
	logic [CNT_W-1:0]          inputs_cfg  = 3'd4;
	logic                      relu_cfg    = 1'b1;

	result_t row_out[$];
	result_t pending[$];
	step_t   script[$];
	result_t no_word    = '0;
	int      errors     = 0;
	int      words_seen = 0;
	int      next_col   = 0;
	bit      steady     = 1'b0;
	bit      held       = 1'b0;

	dense_layer_relu dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #4 clk = ~clk;

	function automatic int active(input logic [CNT_W-1:0] v, input int lim);
		if (v == 0) return 1;
		if (v > lim) return lim;
		return int'(v);
	endfunction

	function automatic item_t mk_item(input logic [1:0] op, input logic [1:0] nrn,
		input logic [1:0] col, input logic [VALUE_W-1:0] v);
		item_t w;
		w.opcode = op;
		w.neuron = nrn;
		w.column = col;
		w.value  = v;
		return w;
	endfunction

	function automatic step_t put(input logic [1:0] op, input logic [1:0] nrn,
		input logic [1:0] col, input logic [VALUE_W-1:0] v);
		step_t s;
		s.setup = 1'b0;
		s.nn    = '0;
		s.ni    = '0;
		s.relu  = 1'b0;
		s.w     = mk_item(op, nrn, col, v);
		s.typed = 1'b0;
		s.want  = '0;
		return s;
	endfunction

	function automatic step_t conf(input logic [CNT_W-1:0] nn, input logic [CNT_W-1:0] ni,
		input logic relu);
		step_t s;
		s       = put(OP_NONE, 2'd0, 2'd0, '0);
		s.setup = 1'b1;
		s.nn    = nn;
		s.ni    = ni;
		s.relu  = relu;
		return s;
	endfunction

	// single active neuron: index 0, last set
	function automatic step_t sure(input step_t s, input logic [VALUE_W-1:0] v, input logic sat);
		step_t t;
		t                   = s;
		t.typed             = 1'b1;
		t.want.neuron_index = 2'd0;
		t.want.neuron_value = v;
		t.want.saturated    = sat;
		t.want.last         = 1'b1;
		return t;
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'h7FFF;
			1: v = 16'h8000;
			2: v = 16'h0000;
			3, 4, 5: v = VALUE_W'($urandom);
			default: v = VALUE_W'($urandom_range(0, 4095)) - 16'd2048;
		endcase
		return v;
	endfunction

	function automatic item_t random_word(input int ni);
		int r;
		int c;
		r = $urandom_range(0, 99);
		if (r < 8) return mk_item(OP_WEIGHT, 2'($urandom), 2'($urandom), pick_value());
		if (r < 13) return mk_item(OP_BIAS, 2'($urandom), 2'($urandom), pick_value());
		if (r < 16) return mk_item(OP_NONE, 2'($urandom), 2'($urandom), pick_value());
		if (r < 20) return mk_item(OP_FEATURE, 2'($urandom), 2'($urandom), pick_value());
		c        = next_col;
		next_col = (next_col + 1) % ni;
		return mk_item(OP_FEATURE, 2'($urandom), 2'(c), pick_value());
	endfunction

	function automatic void neuron_outputs(input item_t w);
		int                          nn;
		int                          ni;
		logic signed [2*VALUE_W-1:0] prod;
		logic signed [47:0]          total;
		logic signed [47:0]          b48;
		result_t                     r;
		nn = active(neurons_cfg, NUM_NEURONS);
		ni = active(inputs_cfg, NUM_INPUTS);
		row_out.delete();
		case (w.opcode)
			OP_WEIGHT: begin
				weights[w.neuron][w.column] = $signed(w.value);
			end
			OP_BIAS: begin
				biases[w.neuron] = $signed(w.value);
			end
			OP_FEATURE: begin
				if (w.column < ni) begin
					for (int n = 0; n < nn; n++) begin
						prod    = $signed(w.value) * weights[n][w.column];
						sums[n] = sums[n] + prod;
					end
					if (w.column == ni - 1) begin
						for (int n = 0; n < nn; n++) begin
							b48   = biases[n];
							total = sums[n];
							total = (total + (b48 <<< FRAC_BITS)) >>> FRAC_BITS;
							r.neuron_index = n[1:0];
							r.saturated    = 1'b0;
							if (total > 32767) begin
								total       = 32767;
								r.saturated = 1'b1;
							end else if (total < -32768) begin
								total       = -32768;
								r.saturated = 1'b1;
							end
							if (relu_cfg && total < 0) total = 0;
							r.neuron_value = total[VALUE_W-1:0];
							r.last         = (n == nn - 1);
							row_out.push_back(r);
						end
						foreach (sums[n]) sums[n] = '0;
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic check_word(input result_t got);
		result_t want;
		words_seen++;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected word: idx %0d val %0d sat %0b last %0b",
					got.neuron_index, $signed(got.neuron_value), got.saturated, got.last);
		end else begin
			want = pending.pop_front();
			if (got.neuron_index !== want.neuron_index || got.neuron_value !== want.neuron_value
				|| got.saturated !== want.saturated || got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected idx %0d val %0d sat %0b last %0b,",
						" got idx %0d val %0d sat %0b last %0b"},
						want.neuron_index, $signed(want.neuron_value), want.saturated, want.last,
						got.neuron_index, $signed(got.neuron_value), got.saturated, got.last);
			end
		end
	endtask

	task automatic offer_item(input item_t w, input bit typed, input result_t want);
		if (!steady && $urandom_range(0, 99) < 10) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (!item_ready);
		neuron_outputs(w);
		if (typed) pending.push_back(want);
		else foreach (row_out[i]) pending.push_back(row_out[i]);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_layer(input logic [CNT_W-1:0] nn, input logic [CNT_W-1:0] ni,
		input logic relu);
		cfg_we    <= 1'b1;
		cfg_index <= REG_NEURONS;
		cfg_data  <= nn;
		@(posedge clk);
		cfg_index <= REG_INPUTS;
		cfg_data  <= ni;
		@(posedge clk);
		cfg_index <= REG_RELU;
		cfg_data  <= CFG_DATA_W'(relu);
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data  <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_we      <= 1'b0;
		neurons_cfg  = nn;
		inputs_cfg   = ni;
		relu_cfg     = relu;
	endtask

	initial begin
		#2_000_000;
		$display("dense_layer_relu test failed");
		$finish;
	end

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) check_word(result);
			// hold off to back up the pipeline
			if (!held && words_seen >= 40) begin
				held = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_ready <= steady || $urandom_range(0, 99) >= 10;
		end
	end

	initial begin
		int ni;
		foreach (sums[n]) sums[n] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		script.push_back(conf(3'd1, 3'd1, 1'b1));
		script.push_back(put(OP_WEIGHT, 2'd0, 2'd0, 16'h7FFF));
		script.push_back(put(OP_BIAS, 2'd0, 2'd0, 16'h8000));
		script.push_back(put(OP_BIAS, 2'd3, 2'd0, 16'h7FFF));
		script.push_back(sure(put(OP_FEATURE, 2'd0, 2'd0, 16'h7FFF), 16'h7FFF, 1'b1));
		script.push_back(sure(put(OP_FEATURE, 2'd0, 2'd0, 16'h8000), 16'h0000, 1'b1));
		script.push_back(conf(3'd1, 3'd1, 1'b0));
		script.push_back(sure(put(OP_FEATURE, 2'd0, 2'd0, 16'h8000), 16'h8000, 1'b1));
		script.push_back(put(OP_NONE, 2'd3, 2'd3, 16'hFFFF));
		script.push_back(put(OP_FEATURE, 2'd0, 2'd3, 16'h7FFF));
		script.push_back(sure(put(OP_FEATURE, 2'd0, 2'd0, 16'h0000), 16'h8000, 1'b0));
		script.push_back(put(OP_BIAS, 2'd0, 2'd0, 16'h0000));
		script.push_back(put(OP_WEIGHT, 2'd0, 2'd0, 16'h0001));
		script.push_back(sure(put(OP_FEATURE, 2'd0, 2'd0, 16'hFFFF), 16'hFFFF, 1'b0));
		script.push_back(conf(3'd0, 3'd7, 1'b1));
		script.push_back(put(OP_WEIGHT, 2'd0, 2'd1, 16'h2000));
		script.push_back(put(OP_WEIGHT, 2'd0, 2'd2, 16'hC000));
		script.push_back(put(OP_WEIGHT, 2'd0, 2'd3, 16'h0800));
		script.push_back(put(OP_FEATURE, 2'd1, 2'd0, 16'h1000));
		script.push_back(put(OP_FEATURE, 2'd2, 2'd0, 16'h1000));
		script.push_back(put(OP_FEATURE, 2'd3, 2'd2, 16'h0400));
		script.push_back(put(OP_FEATURE, 2'd0, 2'd3, 16'h7000));

		foreach (script[i]) begin
			if (script[i].setup) begin
				settle();
				set_layer(script[i].nn, script[i].ni, script[i].relu);
			end else begin
				offer_item(script[i].w, script[i].typed, script[i].want);
			end
		end

		// fill both stores before any full-width row
		for (int n = 0; n < NUM_NEURONS; n++) begin
			for (int c = 0; c < NUM_INPUTS; c++)
				offer_item(mk_item(OP_WEIGHT, 2'(n), 2'(c), pick_value()), 1'b0, no_word);
			offer_item(mk_item(OP_BIAS, 2'(n), 2'($urandom), pick_value()), 1'b0, no_word);
		end

		for (int p = 0; p < 6; p++) begin
			settle();
			set_layer(PLAN_NN[p], PLAN_NI[p], PLAN_RELU[p]);
			steady   = (p == 1);
			next_col = 0;
			ni       = active(inputs_cfg, NUM_INPUTS);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (p == 2 && k == 20) settle();
				offer_item(random_word(ni), 1'b0, no_word);
			end
			// close any open row
			offer_item(mk_item(OP_FEATURE, 2'($urandom), 2'(ni - 1), pick_value()), 1'b0,
				no_word);
		end
		steady = 1'b0;

		settle();
		if (errors == 0 && pending.size() == 0) begin
			$display("dense_layer_relu test passed");
		end else begin
			$display("dense_layer_relu test failed");
		end
		$finish;
	end

endmodule
